/* rtl/assert_macros.svh */
// Assertion helper macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/pidt_pkg.sv */
//------------------------------------------------------------------------------
// pidt_pkg
// Shared types and constants of the timed PID controller.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pidt_pkg;
	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_RESET  = 2'd2;

	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_LIMIT  = 3'd3;
	localparam logic [2:0] REG_WINDOW = 3'd4;

	localparam logic [31:0] WINDOW_RESET = 32'd300000;
	localparam logic [19:0] SCALE_US     = 20'd1000000;

	// 10^6 = 2^6 * 15625; the odd part is divided by reciprocal multiply,
	// ceil(2^44 / 15625), exact for dividends below 2^30
	localparam logic [13:0] SCALE_ODD   = 14'd15625;
	localparam logic [30:0] SCALE_RECIP = 31'd1125899907;

	// divider request: signed dividend / unsigned divisor, truncated
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

/* rtl/pidt_div.sv */
//------------------------------------------------------------------------------
// pidt_div
// Radix-2 restoring divider, signed dividend by unsigned divisor, one
// quotient bit per cycle, quotient truncated toward zero.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pidt_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pidt_pkg::div_req_t   req,
	output pidt_pkg::div_rsp_t   rsp
);
	import pidt_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[63];
			quo_q <= req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 64'd1) : quo_q;
endmodule
`default_nettype wire

/* rtl/pid_controller_timed.sv */
//------------------------------------------------------------------------------
// pid_controller_timed
// Timestamped Q16.16 PID regulator with integral clamp and settle window.
//------------------------------------------------------------------------------
// One item is a transfer on s_axis; one result follows on m_axis. Set target,
// reset, the undefined operation and updates while inactive present their
// result the cycle after the input transfer. An active update computes the
// error, then past the settle window the integral step and, when time has
// elapsed, the derivative: the integral step divides by 10^6 in four
// reciprocal-multiply digit steps on the shared 33x33 multiplier; the
// derivative is a bit-serial division by the elapsed time. The block takes no
// new item until its result has been transferred out of the output register;
// it is ready again the cycle after that transfer.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_timed (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [71:0] s_axis_tdata,  // [1:0] operation, [33:2] value, [65:34] now_us
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] control_out, [32] loop_active
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pidt_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ERR  = 4'd1;
	localparam logic [3:0] ST_IMUL = 4'd2;
	localparam logic [3:0] ST_IDIV = 4'd3;
	localparam logic [3:0] ST_IACC = 4'd4;
	localparam logic [3:0] ST_DMUL = 4'd5;
	localparam logic [3:0] ST_DDIV = 4'd6;
	localparam logic [3:0] ST_P    = 4'd7;
	localparam logic [3:0] ST_I    = 4'd8;
	localparam logic [3:0] ST_D    = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;
	localparam logic [3:0] ST_WAIT = 4'd11;
	localparam logic [3:0] ST_DDLY = 4'd12;
	localparam logic [3:0] ST_QMUL = 4'd13;
	localparam logic [3:0] ST_QSUB = 4'd14;

	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0] limit_q;
	logic [31:0] window_q;
	logic signed [31:0] target_q, prev_err_q, integ_q;
	logic [31:0] restart_q, last_q;
	logic active_q;

	logic [3:0]  state_q;
	logic [31:0] now_q, dt_q;
	logic signed [31:0] val_q, err_q, deriv_q;
	logic        past_q;
	logic signed [67:0] sum_q;
	logic signed [63:0] prod_q;
	logic [31:0] out_ctrl_q;
	logic        out_act_q;
	logic        out_valid_q;

	// integral step: |err*dt| / 10^6, one 16-bit quotient digit per pass
	logic        iq_neg_q;
	logic [63:0] iq_num_q;
	logic [13:0] iq_rem_q;
	logic [63:0] iq_quo_q;
	logic [1:0]  iq_dig_q;
	logic [63:0] prod_mag;
	logic [29:0] iq_num;
	logic [15:0] iq_digit;
	logic [29:0] iq_back;
	logic [29:0] iq_left;
	logic [63:0] iq_sq;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_full;
	div_req_t dreq;
	div_rsp_t drsp;

	pidt_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign mul_full = mul_a * mul_b;

	logic signed [32:0] diff;
	assign diff = {err_q[31], err_q} - {prev_err_q[31], prev_err_q};

	assign prod_mag = prod_q[63] ? (~prod_q + 64'd1) : prod_q;
	assign iq_num   = {iq_rem_q, iq_num_q[63:48]};
	assign iq_digit = prod_q[59:44];
	assign iq_back  = {14'd0, iq_digit} * {16'd0, SCALE_ODD};
	assign iq_left  = iq_num - iq_back;
	assign iq_sq    = iq_neg_q ? (~iq_quo_q + 64'd1) : iq_quo_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IMUL: begin mul_a = {err_q[31], err_q}; mul_b = {1'b0, dt_q}; end
			ST_QMUL: begin mul_a = {3'd0, iq_num}; mul_b = {2'd0, SCALE_RECIP}; end
			ST_DMUL: begin mul_a = diff; mul_b = {13'd0, SCALE_US}; end
			ST_P:    begin mul_a = {gain_p_q[31], gain_p_q}; mul_b = {err_q[31], err_q}; end
			ST_I:    begin mul_a = {gain_i_q[31], gain_i_q}; mul_b = {integ_q[31], integ_q}; end
			ST_D:    begin mul_a = {gain_d_q[31], gain_d_q}; mul_b = {deriv_q[31], deriv_q}; end
			default: ;
		endcase
	end

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -68'sh0_8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	logic signed [67:0] isum;
	logic signed [31:0] isat;
	logic signed [31:0] lim_s;
	assign isum  = {{36{integ_q[31]}}, integ_q} + {{4{iq_sq[63]}}, iq_sq};
	assign isat  = sat32(isum);
	assign lim_s = {1'b0, limit_q};

	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[4:2])
			REG_GAIN_P: prdata = gain_p_q;
			REG_GAIN_I: prdata = gain_i_q;
			REG_GAIN_D: prdata = gain_d_q;
			REG_LIMIT:  prdata = {1'b0, limit_q};
			REG_WINDOW: prdata = window_q;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0; gain_i_q <= '0; gain_d_q <= '0;
			limit_q <= '0; window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_GAIN_P: gain_p_q <= pwdata;
				REG_GAIN_I: gain_i_q <= pwdata;
				REG_GAIN_D: gain_d_q <= pwdata;
				REG_LIMIT:  limit_q  <= pwdata[30:0];
				REG_WINDOW: window_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) prod_q <= mul_full[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			target_q <= '0; prev_err_q <= '0; integ_q <= '0;
			restart_q <= '0; last_q <= '0; active_q <= 1'b0;
			out_valid_q <= 1'b0;
			dreq <= '0;
		end else begin
			dreq.start <= (state_q == ST_DDIV);
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					val_q <= s_axis_tdata[33:2];
					now_q <= s_axis_tdata[65:34];
					out_ctrl_q <= '0;
					if (s_axis_tdata[1:0] == OP_TARGET || s_axis_tdata[1:0] == OP_RESET) begin
						target_q <= (s_axis_tdata[1:0] == OP_TARGET) ? s_axis_tdata[33:2] : '0;
						prev_err_q <= '0; integ_q <= '0;
						restart_q <= s_axis_tdata[65:34];
						active_q <= (s_axis_tdata[1:0] == OP_TARGET);
						out_act_q <= (s_axis_tdata[1:0] == OP_TARGET);
						out_valid_q <= 1'b1;
					end else if (s_axis_tdata[1:0] == OP_UPDATE && active_q) begin
						state_q <= ST_ERR;
					end else begin
						out_act_q <= active_q;
						out_valid_q <= 1'b1;
					end
				end
				ST_ERR: begin
					err_q <= sat32({{36{target_q[31]}}, target_q} - {{36{val_q[31]}}, val_q});
					dt_q <= now_q - last_q;
					past_q <= (now_q - restart_q) > window_q;
					deriv_q <= '0;
					sum_q <= '0;
					state_q <= ((now_q - restart_q) > window_q) ? ST_IMUL : ST_P;
				end
				ST_IMUL: state_q <= ST_IDIV;
				ST_IDIV: begin
					iq_neg_q <= prod_q[63];
					iq_num_q <= {6'd0, prod_mag[63:6]};
					iq_rem_q <= '0;
					iq_quo_q <= '0;
					iq_dig_q <= '0;
					state_q <= ST_QMUL;
				end
				ST_QMUL: state_q <= ST_QSUB;
				ST_QSUB: begin
					iq_quo_q <= {iq_quo_q[47:0], iq_digit};
					iq_num_q <= {iq_num_q[47:0], 16'd0};
					iq_rem_q <= iq_left[13:0];
					iq_dig_q <= iq_dig_q + 2'd1;
					state_q <= (iq_dig_q == 2'd3) ? ST_IACC : ST_QMUL;
				end
				ST_IACC: begin
					if (limit_q != '0 && isat > lim_s) integ_q <= lim_s;
					else if (limit_q != '0 && isat < -lim_s) integ_q <= -lim_s;
					else integ_q <= isat;
					state_q <= (dt_q != '0) ? ST_DMUL : ST_P;
				end
				ST_DMUL: state_q <= ST_DDIV;
				ST_DDIV: begin
					dreq.dividend <= prod_q;
					dreq.divisor <= dt_q;
					state_q <= ST_DDLY;
				end
				ST_DDLY: if (drsp.done) begin
					deriv_q <= sat32($signed(drsp.quotient[63:0]));
					state_q <= ST_P;
				end
				ST_P: begin
					last_q <= now_q;
					prev_err_q <= err_q;
					state_q <= ST_I;
				end
				ST_I: begin
					sum_q <= sum_q + {{4{prod_q[63]}}, prod_q};
					state_q <= ST_D;
				end
				ST_D: begin
					sum_q <= sum_q + {{4{prod_q[63]}}, prod_q};
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					sum_q <= sum_q + {{4{prod_q[63]}}, prod_q};
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					out_ctrl_q <= sat32(sum_q >>> 16);
					out_act_q <= active_q;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_act_q, out_ctrl_q};

	logic unused;
	assign unused = past_q ^ (|s_axis_tdata[71:66]) ^ psel;
endmodule
`default_nettype wire

/* rtl/pidt_checker.sv */
//------------------------------------------------------------------------------
// pidt_checker
// Port-level checks of the timed PID controller, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pidt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire [71:0] s_axis_tdata,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata,
	input wire        pready
);
	import pidt_pkg::*;

	`ASSERT_IMPL(a_no_accept_when_full, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_NEXT(a_ctrl_zero_non_update, clk, arst_n,
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_UPDATE, m_axis_tdata[31:0] == 32'd0)
	`ASSERT_IMPL(a_inactive_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[32],
		m_axis_tdata[31:0] == 32'd0)
	`ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind pid_controller_timed pidt_checker u_pidt_checker (.*);
`default_nettype wire

/* verif/pid_controller_timed_check.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pid_controller_timed_check
// Watches the APB port and both streams of the timed PID controller, keeps its
// own copy of the registers and loop state, predicts each result and compares
// it with what the block sends, field by field.
//------------------------------------------------------------------------------
module pid_controller_timed_check (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [71:0] s_axis_tdata,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [39:0] m_axis_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire         pready,
	output int          fails,
	output int          pending
);
	import pidt_pkg::*;

	typedef struct packed {
		logic        active;
		logic [31:0] drive;
	} pid_result_t;

	logic signed [31:0] kp, ki, kd;
	logic [30:0] clamp_lim;
	logic [31:0] settle_us;

	logic signed [31:0] tgt, prev_err, integ;
	logic [31:0] restart_t, last_t;
	logic active;

	pid_result_t drive_q[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		fails++;
	endtask

	function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'h7fffffff;
		if (v < -128'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic pid_result_t pid_step(input logic [1:0] op, input logic signed [31:0] val,
			input logic [31:0] now);
		logic signed [63:0] err64, acc, diff, deriv;
		logic signed [31:0] err, ia, lim;
		logic [31:0] dt;
		logic signed [127:0] a, b, sum;
		pid_result_t r;
		r.drive = 0;
		if (op == OP_TARGET || op == OP_RESET) begin
			tgt = (op == OP_TARGET) ? val : 32'sd0;
			prev_err = 0;
			integ = 0;
			restart_t = now;
			active = (op == OP_TARGET);
		end else if (op == OP_UPDATE && active) begin
			err64 = tgt;
			err64 = err64 - val;
			err = sat32(err64);
			deriv = 0;
			if ((now - restart_t) > settle_us) begin
				dt = now - last_t;
				acc = err;
				acc = acc * $signed({32'd0, dt});
				acc = acc / 64'sd1000000;
				acc = acc + integ;
				ia = sat32(acc);
				if (clamp_lim != 0) begin
					lim = $signed({1'b0, clamp_lim});
					if (ia > lim) ia = lim;
					else if (ia < -lim) ia = -lim;
				end
				integ = ia;
				if (dt != 0) begin
					diff = err;
					diff = diff - prev_err;
					diff = diff * 64'sd1000000;
					deriv = sat32(diff / $signed({32'd0, dt}));
				end
			end
			last_t = now;
			prev_err = err;
			a = kp; b = err; sum = a * b;
			a = ki; b = integ; sum = sum + a * b;
			a = kd; b = deriv; sum = sum + a * b;
			sum = sum >>> 16;
			r.drive = sat32(sum);
		end
		r.active = active;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pid_result_t want;
		if (!arst_n) begin
			kp = 0; ki = 0; kd = 0; clamp_lim = 0; settle_us = WINDOW_RESET;
			tgt = 0; prev_err = 0; integ = 0; restart_t = 0; last_t = 0; active = 0;
			drive_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
				REG_GAIN_P: kp = pwdata;
				REG_GAIN_I: ki = pwdata;
				REG_GAIN_D: kd = pwdata;
				REG_LIMIT:  clamp_lim = pwdata[30:0];
				REG_WINDOW: settle_us = pwdata;
				default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				drive_q.push_back(pid_step(s_axis_tdata[1:0], s_axis_tdata[33:2],
					s_axis_tdata[65:34]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					report("unexpected result", m_axis_tdata[31:0], 32'd0);
				end else begin
					want = drive_q.pop_front();
					if (m_axis_tdata[31:0] !== want.drive)
						report("control_out", m_axis_tdata[31:0], want.drive);
					if (m_axis_tdata[32] !== want.active)
						report("loop_active", {31'd0, m_axis_tdata[32]}, {31'd0, want.active});
				end
			end
			pending = drive_q.size();
		end
	end
endmodule

/* verif/pid_controller_timed_test.sv */
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// pid_controller_timed_test
// Drives the timed PID controller through register settings from reset values
// to extremes, a directed list of corner items and random target/update
// sequences with noise, under random idling on both streams and one long
// output stall. The checker beside the block predicts and compares.
//------------------------------------------------------------------------------
module pid_controller_timed_test;
	import pidt_pkg::*;

	logic        clk, arst_n;
	logic        s_axis_tvalid, m_axis_tready;
	logic [71:0] s_axis_tdata;
	wire         s_axis_tready, m_axis_tvalid;
	wire  [39:0] m_axis_tdata;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;
	int          fails, pending;

	logic        calm;
	logic        hold_req;
	int          n_sent, n_phases;
	logic [31:0] cur_t, win;

	pid_controller_timed u_dut (.*);
	pid_controller_timed_check u_check (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_axis_tready <= 0;
				repeat (600) @(negedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic push_item(input logic [1:0] op, input logic [31:0] val, input logic [31:0] now);
		while (!calm && $urandom_range(0, 99) < 26) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, now, val, op};
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic configure(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
			input logic [31:0] lim, input logic [31:0] w);
		@(negedge clk);
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		apb_write(REG_GAIN_P, p);
		apb_write(REG_GAIN_I, i);
		apb_write(REG_GAIN_D, d);
		apb_write(REG_LIMIT, lim);
		apb_write(REG_WINDOW, w);
		win = w;
		n_phases++;
	endtask

	function automatic logic [31:0] rand_gain();
		if ($urandom_range(0, 2) == 0) return $urandom;
		return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
	endfunction

	function automatic logic [31:0] rand_val();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
	endfunction

	function automatic logic [31:0] rand_step();
		case ($urandom_range(0, 9))
		0: return 0;
		1: return $urandom;
		2, 3, 4: return $urandom_range(1, 200000);
		default: return $urandom_range(1, 2000);
		endcase
	endfunction

	task automatic random_items(input int count);
		int k, left;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 85) begin
				cur_t += rand_step();
				push_item(OP_TARGET, rand_val(), cur_t);
				left--;
				if ($urandom_range(0, 1) && win < 32'h8000_0000)
					cur_t += win + $urandom_range(0, 100);
				k = $urandom_range(2, 12);
				repeat (k) begin
					cur_t += rand_step();
					push_item(($urandom_range(0, 19) == 0) ? OP_RESET : OP_UPDATE,
						rand_val(), cur_t);
					left--;
				end
			end else begin
				push_item(2'($urandom_range(0, 3)), $urandom,
					$urandom_range(0, 1) ? $urandom : cur_t + rand_step());
				left--;
			end
		end
	endtask

	initial begin
		arst_n = 0; calm = 0; hold_req = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		n_sent = 0; n_phases = 0; cur_t = 0; win = WINDOW_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset register values: every output is zero
		random_items(60);

		// directed corners with unit gains and a short settle window
		configure(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'd1000);
		push_item(OP_UPDATE, 32'h0001_0000, 32'd10);
		push_item(OP_TARGET, 32'h0005_0000, 32'd100);
		push_item(OP_UPDATE, 32'h0002_0000, 32'd500);
		push_item(OP_UPDATE, 32'h0002_0000, 32'd1100);
		push_item(OP_UPDATE, 32'h0001_0000, 32'd2100);
		push_item(OP_UPDATE, 32'h0000_0000, 32'd2100);
		push_item(OP_UPDATE, 32'h8000_0000, 32'd52100);
		push_item(2'd3, 32'hffff_ffff, 32'hffff_ffff);
		push_item(OP_TARGET, 32'h7fff_ffff, 32'd3000);
		push_item(OP_UPDATE, 32'h8000_0000, 32'd5000);
		push_item(OP_UPDATE, 32'h7fff_ffff, 32'd900000);
		push_item(OP_TARGET, 32'h8000_0000, 32'hffff_fc00);
		push_item(OP_UPDATE, 32'h7fff_ffff, 32'h0000_0200);
		push_item(OP_UPDATE, 32'h0000_0000, 32'h0000_0300);
		push_item(OP_RESET, 32'h1234_5678, 32'h0000_0400);
		push_item(OP_UPDATE, 32'h0001_0000, 32'h0010_0000);
		push_item(2'd3, 32'h0000_0000, 32'h0000_0000);

		// extremes
		configure(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
		random_items(120);
		configure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'hffff_ffff);
		random_items(60);
		configure(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd0);
		random_items(80);

		// output held off while items keep coming
		configure(rand_gain(), rand_gain(), rand_gain(), 32'h0004_0000, 32'd500);
		hold_req = 1;
		random_items(60);

		// stretch without any idling
		calm = 1;
		configure(rand_gain(), rand_gain(), rand_gain(), 32'd0, WINDOW_RESET);
		random_items(120);
		calm = 0;

		repeat (9) begin
			configure(rand_gain(), rand_gain(), rand_gain(),
				$urandom_range(0, 1) ? 32'd0 : $urandom_range(0, 32'h7fff_ffff),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000));
			random_items(120);
		end

		@(negedge clk);
		s_axis_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d items sent over %0d register settings", n_sent, n_phases);
		$display("covered targets, resets, updates inside and past the window, clamp and wrap");
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* pid_controller_timed.f */
+incdir+rtl
rtl/pidt_pkg.sv
rtl/pidt_div.sv
rtl/pid_controller_timed.sv
rtl/pidt_checker.sv
verif/pid_controller_timed_check.sv
verif/pid_controller_timed_test.sv
